// ----- sv/assert_macros.svh -----
// Assertion macros shared by the decompressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rlzd_pkg.sv -----
// Types, codes and helper functions of the run-length/LZ byte decompressor.
package rlzd_pkg;

	// Item commands.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_PUSH  = 2'd1;
	localparam logic [1:0] CMD_CONT  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_BADOFF = 3'd2;
	localparam logic [2:0] ST_TRUNC  = 3'd3;
	localparam logic [2:0] ST_MISUSE = 3'd4;

	// Header byte constants.
	localparam logic [7:0] HDR_END = 8'hFF;
	localparam logic [2:0] HDR_EXT = 3'b111;

	// Saturation point of the output byte count.
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_EXTLEN  = 6'b000010,
		PH_LITERAL = 6'b000100,
		PH_OPER1   = 6'b001000,
		PH_OPER2   = 6'b010000,
		PH_RUN     = 6'b100000
	} phase_t;

	// Kind of the command being decoded.
	typedef enum logic [2:0] {
		K_LITERAL = 3'd0,
		K_FILL    = 3'd1,
		K_ALT     = 3'd2,
		K_INC     = 3'd3,
		K_COPY    = 3'd4
	} kind_t;

	// Maps the three command bits of a header to a run kind.
	function automatic kind_t kind_of(input logic [2:0] code);
		kind_t k;
		if (code == 3'b000) begin
			k = K_LITERAL;
		end else if (code[2]) begin
			k = K_COPY;
		end else if (!code[1]) begin
			k = K_FILL;
		end else if (!code[0]) begin
			k = K_ALT;
		end else begin
			k = K_INC;
		end
		return k;
	endfunction

endpackage

// ----- sv/rlzd_if.sv -----
// Handshake interfaces of the decompressor: input words, result words, configuration.

// Input word channel.
interface rlzd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] source_byte;
	logic       last_source_byte;

	modport source (output valid, command, source_byte, last_source_byte, input ready);
	modport sink (input valid, command, source_byte, last_source_byte, output ready);
endinterface

// Result word channel.
interface rlzd_out_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] out_byte;
	logic       run_pending;
	logic [2:0] status;

	modport source (output valid, data_valid, out_byte, run_pending, status, input ready);
	modport sink (input valid, data_valid, out_byte, run_pending, status, output ready);
endinterface

// Configuration write channel for the copy offset byte order.
interface rlzd_cfg_if;
	logic valid;
	logic ready;
	logic offsets_big_endian;

	modport source (output valid, offsets_big_endian, input ready);
	modport sink (input valid, offsets_big_endian, output ready);
endinterface

// ----- sv/rle_lz_byte_decompressor.sv -----
// Top level of the run-length/LZ byte decompressor with its history memory.
//
//  channel | modport      | word carries
//  --------+--------------+-------------------------------------------------
//  src     | rlzd_in_if   | command, source_byte, last_source_byte
//  dst     | rlzd_out_if  | data_valid, out_byte, run_pending, status
//  cfg     | rlzd_cfg_if  | offsets_big_endian (always ready)
//
// One input word is taken per cycle while the pipeline is not stalled; every word
// yields one result word through the decode stage, then the output register.
// The history memory has one read and one write port; a copy byte is read in
// the accept cycle and written back one stage later, with forwarding when the
// copy source is the byte being written in that same cycle.
// Reset clears all control state; the history memory holds no reset value.
// A stall on dst fills the output register and then the decode stage, and
// only then is src held off.
module rle_lz_byte_decompressor
	import rlzd_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input logic          clk,
	input logic          arst_n,
	rlzd_in_if.sink      src,
	rlzd_out_if.source   dst,
	rlzd_cfg_if.sink     cfg
);

	`include "assert_macros.svh"

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned RW = 22;
	localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);

	// Stream state.
	logic [16:0]   bytes_written_q, bytes_written_n;
	phase_t        phase_q, phase_n;
	kind_t         kind_q, kind_n;
	logic [10:0]   remaining_q, remaining_n;
	logic [7:0]    op_low_q, op_low_n;
	logic [7:0]    op_high_q, op_high_n;
	logic [AW-1:0] copy_ptr_q, copy_ptr_n;
	logic [AW-1:0] wslot_q, wslot_n;
	logic          toggle_q, toggle_n;
	logic          exhausted_q, exhausted_n;
	logic          closed_q, closed_n;
	logic          big_endian_q;

	// Result of the word being accepted.
	logic          emit_n;
	logic          copy_rd_n;
	logic [7:0]    res_byte_n;
	logic [2:0]    res_status_n;
	logic          res_pending_n;
	logic          fwd_n;

	// Decode stage.
	logic          valid_s1;
	logic          data_valid_s1;
	logic [7:0]    byte_s1;
	logic [2:0]    status_s1;
	logic          pending_s1;
	logic          copy_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0]    hist_rdata_s1;
	logic [7:0]    final_byte_s1;
	logic          adv_s1;

	// Output register.
	logic          ovalid_q;
	logic          odv_q;
	logic [7:0]    obyte_q;
	logic          opend_q;
	logic [2:0]    ostat_q;

	logic          acc;
	logic [15:0]   offset;
	logic [RW-1:0] off_red;

	logic [7:0]    hist_mem [HISTORY_DEPTH];

	assign acc = src.valid && src.ready;
	assign adv_s1 = valid_s1 && (!ovalid_q || dst.ready);
	assign src.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	assign final_byte_s1 = copy_s1 ? (fwd_s1 ? fwd_data_s1 : hist_rdata_s1) : byte_s1;

	// Copy offset in the configured byte order, the second byte arriving now.
	assign offset = big_endian_q ? {op_low_q, src.source_byte} : {src.source_byte, op_low_q};

	// Offset modulo the history depth by conditional subtraction; the quotient
	// is below 64 as long as the depth is at least 1024.
	always_comb begin
		off_red = RW'(offset);
		for (int k = 5; k >= 0; k--) begin
			if (off_red >= (RW'(HISTORY_DEPTH) << k)) begin
				off_red = off_red - (RW'(HISTORY_DEPTH) << k);
			end
		end
	end

	// Next stream state and result of the presented word.
	always_comb begin
		bytes_written_n = bytes_written_q;
		phase_n         = phase_q;
		kind_n          = kind_q;
		remaining_n     = remaining_q;
		op_low_n        = op_low_q;
		op_high_n       = op_high_q;
		copy_ptr_n      = copy_ptr_q;
		wslot_n         = wslot_q;
		toggle_n        = toggle_q;
		exhausted_n     = exhausted_q;
		closed_n        = closed_q;
		emit_n          = 1'b0;
		copy_rd_n       = 1'b0;
		res_byte_n      = 8'h00;
		res_status_n    = ST_OK;

		if (src.command == CMD_START) begin
			bytes_written_n = '0;
			phase_n         = PH_HEADER;
			kind_n          = K_LITERAL;
			remaining_n     = '0;
			op_low_n        = '0;
			op_high_n       = '0;
			copy_ptr_n      = '0;
			wslot_n         = '0;
			toggle_n        = 1'b0;
			exhausted_n     = 1'b0;
			closed_n        = 1'b0;
		end else if (closed_q || (src.command != CMD_PUSH && src.command != CMD_CONT)) begin
			res_status_n = ST_MISUSE;
		end else if (src.command == CMD_CONT) begin
			// Pay out one byte of a fill, alternating, increment or copy run.
			if (phase_q != PH_RUN || remaining_q == '0) begin
				res_status_n = ST_MISUSE;
			end else begin
				case (kind_q)
					K_ALT: begin
						res_byte_n = toggle_q ? op_high_q : op_low_q;
						toggle_n   = !toggle_q;
					end
					K_INC: begin
						res_byte_n = op_low_q;
						op_low_n   = op_low_q + 8'd1;
					end
					K_COPY: begin
						copy_rd_n  = 1'b1;
						copy_ptr_n = (copy_ptr_q == SLOT_LAST) ? '0 : copy_ptr_q + 1'b1;
					end
					default: begin
						res_byte_n = op_low_q;
					end
				endcase
				emit_n      = 1'b1;
				remaining_n = remaining_q - 11'd1;
				if (remaining_q == 11'd1) begin
					phase_n = PH_HEADER;
					if (exhausted_q) begin
						res_status_n = ST_DONE;
						closed_n     = 1'b1;
						remaining_n  = '0;
					end
				end
			end
		end else if (phase_q == PH_RUN) begin
			res_status_n = ST_MISUSE;
		end else begin
			// Push of one compressed byte.
			unique case (phase_q)
				PH_HEADER: begin
					if (src.source_byte == HDR_END) begin
						res_status_n = ST_DONE;
						closed_n     = 1'b1;
						phase_n      = PH_HEADER;
						remaining_n  = '0;
					end else if (src.source_byte[7:5] != HDR_EXT) begin
						kind_n      = kind_of(src.source_byte[7:5]);
						remaining_n = 11'(src.source_byte[4:0]) + 11'd1;
						toggle_n    = 1'b0;
						phase_n     = (kind_of(src.source_byte[7:5]) == K_LITERAL) ?
							PH_LITERAL : PH_OPER1;
						if (src.last_source_byte) begin
							res_status_n = ST_TRUNC;
							closed_n     = 1'b1;
							phase_n      = PH_HEADER;
							remaining_n  = '0;
						end
					end else begin
						kind_n      = kind_of(src.source_byte[4:2]);
						remaining_n = {1'b0, src.source_byte[1:0], 8'h00};
						phase_n     = PH_EXTLEN;
						if (src.last_source_byte) begin
							res_status_n = ST_TRUNC;
							closed_n     = 1'b1;
							phase_n      = PH_HEADER;
							remaining_n  = '0;
						end
					end
				end
				PH_EXTLEN: begin
					remaining_n = {1'b0, remaining_q[9:8], src.source_byte} + 11'd1;
					toggle_n    = 1'b0;
					phase_n     = (kind_q == K_LITERAL) ? PH_LITERAL : PH_OPER1;
					if (src.last_source_byte) begin
						res_status_n = ST_TRUNC;
						closed_n     = 1'b1;
						phase_n      = PH_HEADER;
						remaining_n  = '0;
					end
				end
				PH_LITERAL: begin
					if (src.last_source_byte && remaining_q > 11'd1) begin
						res_status_n = ST_TRUNC;
						closed_n     = 1'b1;
						phase_n      = PH_HEADER;
						remaining_n  = '0;
					end else begin
						emit_n      = 1'b1;
						res_byte_n  = src.source_byte;
						remaining_n = remaining_q - 11'd1;
						if (remaining_q == 11'd1) begin
							phase_n = PH_HEADER;
						end
						if (src.last_source_byte) begin
							res_status_n = ST_DONE;
							closed_n     = 1'b1;
							phase_n      = PH_HEADER;
							remaining_n  = '0;
						end
					end
				end
				PH_OPER1: begin
					op_low_n = src.source_byte;
					if (kind_q == K_ALT || kind_q == K_COPY) begin
						phase_n = PH_OPER2;
						if (src.last_source_byte) begin
							res_status_n = ST_TRUNC;
							closed_n     = 1'b1;
							phase_n      = PH_HEADER;
							remaining_n  = '0;
						end
					end else begin
						phase_n = PH_RUN;
						if (src.last_source_byte) begin
							exhausted_n = 1'b1;
						end
					end
				end
				PH_OPER2: begin
					op_high_n = src.source_byte;
					if (kind_q == K_COPY && {1'b0, offset} >= bytes_written_q) begin
						res_status_n = ST_BADOFF;
						closed_n     = 1'b1;
						phase_n      = PH_HEADER;
						remaining_n  = '0;
					end else begin
						if (kind_q == K_COPY) begin
							copy_ptr_n = off_red[AW-1:0];
						end
						phase_n = PH_RUN;
						if (src.last_source_byte) begin
							exhausted_n = 1'b1;
						end
					end
				end
				default: begin
					res_status_n = ST_MISUSE;
				end
			endcase
		end

		// Advance the write slot and the saturating byte count on output.
		if (emit_n) begin
			wslot_n = (wslot_q == SLOT_LAST) ? '0 : wslot_q + 1'b1;
			if (bytes_written_q != COUNT_MAX) begin
				bytes_written_n = bytes_written_q + 17'd1;
			end
		end

		res_pending_n = !closed_n && phase_n == PH_RUN && remaining_n != '0;
	end

	// A copy read hits the byte that the decode stage writes in this cycle.
	assign fwd_n = copy_rd_n && adv_s1 && data_valid_s1 && (waddr_s1 == copy_ptr_q);

	// Stream state registers and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_written_q <= '0;
			phase_q         <= PH_HEADER;
			kind_q          <= K_LITERAL;
			remaining_q     <= '0;
			op_low_q        <= '0;
			op_high_q       <= '0;
			copy_ptr_q      <= '0;
			wslot_q         <= '0;
			toggle_q        <= 1'b0;
			exhausted_q     <= 1'b0;
			closed_q        <= 1'b1;
			big_endian_q    <= 1'b1;
		end else begin
			if (acc) begin
				bytes_written_q <= bytes_written_n;
				phase_q         <= phase_n;
				kind_q          <= kind_n;
				remaining_q     <= remaining_n;
				op_low_q        <= op_low_n;
				op_high_q       <= op_high_n;
				copy_ptr_q      <= copy_ptr_n;
				wslot_q         <= wslot_n;
				toggle_q        <= toggle_n;
				exhausted_q     <= exhausted_n;
				closed_q        <= closed_n;
			end
			if (cfg.valid) begin
				big_endian_q <= cfg.offsets_big_endian;
			end
		end
	end

	// Decode stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	// Decode stage payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			data_valid_s1 <= emit_n;
			byte_s1       <= res_byte_n;
			status_s1     <= res_status_n;
			pending_s1    <= res_pending_n;
			copy_s1       <= copy_rd_n;
			fwd_s1        <= fwd_n;
			fwd_data_s1   <= final_byte_s1;
			waddr_s1      <= wslot_q;
		end
	end

	// History memory: read at accept, write when the decode stage moves on.
	always_ff @(posedge clk) begin
		if (adv_s1 && data_valid_s1) begin
			hist_mem[waddr_s1] <= final_byte_s1;
		end
		if (acc) begin
			hist_rdata_s1 <= hist_mem[copy_ptr_q];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv_s1) begin
			ovalid_q <= 1'b1;
		end else if (dst.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			odv_q   <= data_valid_s1;
			obyte_q <= data_valid_s1 ? final_byte_s1 : 8'h00;
			opend_q <= pending_s1;
			ostat_q <= status_s1;
		end
	end

	assign dst.valid       = ovalid_q;
	assign dst.data_valid  = odv_q;
	assign dst.out_byte    = obyte_q;
	assign dst.run_pending = opend_q;
	assign dst.status      = ostat_q;

	// Checks on the pipeline and the parser state.
	`ASSERT_IMPLY(a_closed_idle, closed_q, phase_q == PH_HEADER && remaining_q == '0, "closed stream holds a run")
	`ASSERT_IMPLY(a_run_nonzero, phase_q == PH_RUN, remaining_q != '0, "run phase with empty run")
	`ASSERT_IMPLY(a_stall_cause, !src.ready, valid_s1 && ovalid_q && !dst.ready, "input held off without a full pipeline")
	`ASSERT_NEXT(a_start_opens, acc && src.command == CMD_START, !closed_q, "start did not open the stream")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the run-length/LZ byte decompressor.
module tb
	import rlzd_pkg::*;
();

	// The one command code that the package leaves unnamed.
	localparam logic [1:0] CMD_ILLEGAL = 2'd3;

	// Command field of a header byte.
	localparam logic [2:0] HC_LITERAL = 3'b000;
	localparam logic [2:0] HC_FILL    = 3'b001;
	localparam logic [2:0] HC_ALT     = 3'b010;
	localparam logic [2:0] HC_INC     = 3'b011;
	localparam logic [2:0] HC_COPY    = 3'b100;

	localparam int HOLD_CYCLES = 200;
	localparam longint RUN_LIMIT = 64'd14_000_000;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic       run_pending;
		logic [2:0] status;
	} result_t;

	logic clk;
	logic arst_n;

	rlzd_in_if  src_if ();
	rlzd_out_if dst_if ();
	rlzd_cfg_if cfg_if ();

	rle_lz_byte_decompressor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.dst    (dst_if),
		.cfg    (cfg_if)
	);

	// Decoder state mirrored by the predictor.
	logic [7:0]  hist_mem [0:65535];
	logic [15:0] hist_slot;
	logic [16:0] out_count;
	phase_t      phase;
	kind_t       kind;
	logic [10:0] run_left;
	logic [7:0]  op_a;
	logic [7:0]  op_b;
	logic [15:0] copy_ptr;
	logic        alt_sel;
	logic        src_done;
	logic        closed;
	logic        cfg_big_endian;

	result_t pending_results [$];
	int      fail_count = 0;
	int      counted_words = 0;
	bit      src_idle_on = 1'b1;
	bit      dst_idle_on = 1'b1;
	logic    hold_on;
	event    hold_ev;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(10, 25);
	endfunction

	function automatic kind_t kind_from_code(input logic [2:0] code);
		case (code)
			HC_LITERAL: return K_LITERAL;
			HC_FILL:    return K_FILL;
			HC_ALT:     return K_ALT;
			HC_INC:     return K_INC;
			default:    return K_COPY;
		endcase
	endfunction

	function automatic void clear_stream();
		hist_slot = '0;
		out_count = '0;
		phase = PH_HEADER;
		kind = K_LITERAL;
		run_left = '0;
		op_a = '0;
		op_b = '0;
		copy_ptr = '0;
		alt_sel = 1'b0;
		src_done = 1'b0;
	endfunction

	function automatic void close_stream();
		closed = 1'b1;
		phase = PH_HEADER;
		run_left = '0;
	endfunction

	function automatic void record_byte(input logic [7:0] v);
		hist_mem[hist_slot] = v;
		hist_slot = hist_slot + 16'd1;
		if (out_count != COUNT_MAX) begin
			out_count = out_count + 17'd1;
		end
	endfunction

	// Works out the result word of one accepted input word and advances the decoder state.
	function automatic result_t decompress_step(input logic [1:0] cmd, input logic [7:0] b,
			input logic last);
		result_t r;
		logic opened;
		logic [15:0] off;
		r = '0;
		r.status = ST_OK;
		opened = 1'b0;
		off = '0;
		if (cmd == CMD_START) begin
			clear_stream();
			closed = 1'b0;
		end else if (cmd == CMD_ILLEGAL || closed) begin
			r.status = ST_MISUSE;
		end else if (cmd == CMD_CONT) begin
			if (phase != PH_RUN || run_left == 0) begin
				r.status = ST_MISUSE;
			end else begin
				case (kind)
					K_ALT: begin
						r.out_byte = alt_sel ? op_b : op_a;
						alt_sel = ~alt_sel;
					end
					K_INC: begin
						r.out_byte = op_a;
						op_a = op_a + 8'd1;
					end
					K_COPY: begin
						r.out_byte = hist_mem[copy_ptr];
						copy_ptr = copy_ptr + 16'd1;
					end
					default: r.out_byte = op_a;
				endcase
				record_byte(r.out_byte);
				r.data_valid = 1'b1;
				run_left = run_left - 11'd1;
				if (run_left == 0) begin
					phase = PH_HEADER;
					if (src_done) begin
						r.status = ST_DONE;
						close_stream();
					end
				end
			end
		end else if (phase == PH_RUN) begin
			r.status = ST_MISUSE;
		end else begin
			case (phase)
				PH_HEADER: begin
					if (b == HDR_END) begin
						r.status = ST_DONE;
						close_stream();
					end else if (b[7:5] != HDR_EXT) begin
						kind = kind_from_code(b[7:5]);
						run_left = 11'(b[4:0]) + 11'd1;
						opened = 1'b1;
					end else begin
						kind = kind_from_code(b[4:2]);
						run_left = {1'b0, b[1:0], 8'h00};
						phase = PH_EXTLEN;
						if (last) begin
							r.status = ST_TRUNC;
							close_stream();
						end
					end
				end
				PH_EXTLEN: begin
					run_left = {1'b0, run_left[9:8], b} + 11'd1;
					opened = 1'b1;
				end
				PH_LITERAL: begin
					if (last && run_left > 1) begin
						// A final byte while more literal bytes are owed is dropped.
						r.status = ST_TRUNC;
						close_stream();
					end else begin
						record_byte(b);
						r.data_valid = 1'b1;
						r.out_byte = b;
						run_left = run_left - 11'd1;
						if (run_left == 0) begin
							phase = PH_HEADER;
						end
						if (last) begin
							r.status = ST_DONE;
							close_stream();
						end
					end
				end
				PH_OPER1: begin
					op_a = b;
					if (kind == K_ALT || kind == K_COPY) begin
						phase = PH_OPER2;
						if (last) begin
							r.status = ST_TRUNC;
							close_stream();
						end
					end else begin
						phase = PH_RUN;
						if (last) begin
							src_done = 1'b1;
						end
					end
				end
				default: begin
					op_b = b;
					if (kind == K_COPY) begin
						off = cfg_big_endian ? {op_a, op_b} : {op_b, op_a};
					end
					if (kind == K_COPY && {1'b0, off} >= out_count) begin
						r.status = ST_BADOFF;
						close_stream();
					end else begin
						if (kind == K_COPY) begin
							copy_ptr = off;
						end
						phase = PH_RUN;
						if (last) begin
							src_done = 1'b1;
						end
					end
				end
			endcase
			if (opened) begin
				alt_sel = 1'b0;
				phase = (kind == K_LITERAL) ? PH_LITERAL : PH_OPER1;
				if (last) begin
					r.status = ST_TRUNC;
					close_stream();
				end
			end
		end
		r.run_pending = !closed && phase == PH_RUN && run_left != 0;
		return r;
	endfunction

	// Offers one input word, waits for it to be taken and records its expected result.
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] b, input logic last);
		int gap;
		result_t want;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.command <= cmd;
		src_if.source_byte <= b;
		src_if.last_source_byte <= last;
		@(posedge clk);
		while (!src_if.ready) @(posedge clk);
		want = decompress_step(cmd, b, last);
		pending_results.push_back(want);
		if (want.status != ST_MISUSE) begin
			counted_words++;
		end
	endtask

	task automatic feed(input logic [7:0] b, input logic last);
		send_word(CMD_PUSH, b, last);
	endtask

	task automatic pay_out(input int n);
		repeat (n) send_word(CMD_CONT, 8'($urandom), 1'($urandom));
	endtask

	task automatic open_stream();
		send_word(CMD_START, 8'($urandom), 1'($urandom));
	endtask

	// Stops offering words and waits until every expected result has come.
	task automatic wait_idle();
		src_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_byte_order(input logic big_endian);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.offsets_big_endian <= big_endian;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		cfg_big_endian = big_endian;
	endtask

	// Now and then slips in a word that the block must refuse without a state change.
	task automatic maybe_noise();
		if ($urandom_range(0, 99) < 3) begin
			if ($urandom_range(0, 1) == 0) begin
				send_word(CMD_ILLEGAL, 8'($urandom), 1'($urandom));
			end else if (phase == PH_RUN) begin
				send_word(CMD_PUSH, 8'($urandom), 1'($urandom));
			end else begin
				send_word(CMD_CONT, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Builds one random command, sends it and pays out its run.
	task automatic send_command(input bit last_cmd, input bit cut_short, output bit ended);
		kind_t k;
		int r;
		int len;
		int cut_at;
		bit ext;
		logic [2:0] code;
		logic [9:0] lm1;
		logic [15:0] off;
		logic [7:0] bytes_q [$];
		k = kind_t'($urandom_range(0, 4));
		if (k == K_COPY && out_count == 0 && $urandom_range(0, 3) != 0) begin
			k = K_FILL;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			len = $urandom_range(1, 8);
		end else if (r < 90) begin
			len = $urandom_range(9, 32);
		end else if (r < 98) begin
			len = $urandom_range(1, 64);
		end else begin
			len = $urandom_range(65, 300);
		end
		ext = (len > 32) || ($urandom_range(0, 9) == 0);
		lm1 = 10'(len - 1);
		case (k)
			K_LITERAL: code = HC_LITERAL;
			K_FILL:    code = HC_FILL;
			K_ALT:     code = HC_ALT;
			K_INC:     code = HC_INC;
			default:   code = ext ? 3'($urandom_range(4, 7)) : 3'($urandom_range(4, 6));
		endcase
		if (ext) begin
			bytes_q.push_back({HDR_EXT, code, lm1[9:8]});
			bytes_q.push_back(lm1[7:0]);
		end else begin
			bytes_q.push_back({code, lm1[4:0]});
		end
		case (k)
			K_LITERAL: repeat (len) bytes_q.push_back(8'($urandom));
			K_FILL, K_INC: bytes_q.push_back(8'($urandom));
			K_ALT: begin
				bytes_q.push_back(8'($urandom));
				bytes_q.push_back(8'($urandom));
			end
			default: begin
				// Mostly a good offset, sometimes one at or past the output size.
				r = $urandom_range(0, 99);
				if (out_count == 0 || r < 5) begin
					off = out_count[15:0];
				end else if (r < 8) begin
					off = 16'($urandom);
				end else begin
					off = 16'($urandom_range(0, int'(out_count) - 1));
				end
				if (cfg_big_endian) begin
					bytes_q.push_back(off[15:8]);
					bytes_q.push_back(off[7:0]);
				end else begin
					bytes_q.push_back(off[7:0]);
					bytes_q.push_back(off[15:8]);
				end
			end
		endcase
		cut_at = cut_short ? $urandom_range(0, bytes_q.size() - 1) : -1;
		foreach (bytes_q[i]) begin
			maybe_noise();
			feed(bytes_q[i], (i == cut_at) || (last_cmd && i == bytes_q.size() - 1));
			if (closed) begin
				ended = 1'b1;
				return;
			end
		end
		while (phase == PH_RUN && run_left != 0) begin
			maybe_noise();
			pay_out(1);
		end
		ended = closed;
	endtask

	// One random stream: a start, some commands and one of several endings.
	task automatic send_stream();
		int n;
		int ending;
		bit ended;
		if ($urandom_range(0, 99) < 15) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			dst_idle_on = ($urandom_range(0, 3) != 0);
		end
		open_stream();
		n = $urandom_range(1, 10);
		ending = $urandom_range(0, 9);
		ended = 1'b0;
		for (int i = 0; i < n && !ended; i++) begin
			send_command((ending == 6 || ending == 7) && i == n - 1, ending == 8 && i == n - 1,
				ended);
		end
		if (!ended && ending <= 5) begin
			feed(HDR_END, 1'($urandom));
		end
		// Words sent after the stream has closed.
		if (closed) begin
			repeat ($urandom_range(0, 2)) begin
				send_word($urandom_range(0, 1) ? CMD_PUSH : CMD_CONT, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Every command kind at least once, with byte extremes and the increment wrap.
	task automatic test_directed_commands();
		open_stream();
		feed({HC_LITERAL, 5'd0}, 1'b0);
		feed(8'hFF, 1'b0);
		feed({HC_LITERAL, 5'd1}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h5A, 1'b0);
		feed({HC_FILL, 5'd1}, 1'b0);
		feed(8'hA5, 1'b0);
		pay_out(2);
		// An odd alternating run ends on the first byte.
		feed({HC_ALT, 5'd2}, 1'b0);
		feed(8'h12, 1'b0);
		feed(8'h34, 1'b0);
		pay_out(3);
		feed({HC_INC, 5'd1}, 1'b0);
		feed(8'hFF, 1'b0);
		pay_out(2);
		feed({HC_COPY, 5'd1}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h01, 1'b0);
		pay_out(2);
		feed(HDR_END, 1'b0);
		wait_idle();
	endtask

	// Words that must be refused with the state left as it was.
	task automatic test_misuse();
		send_word(CMD_ILLEGAL, 8'h00, 1'b0);
		feed(8'h00, 1'b0);
		pay_out(1);
		open_stream();
		pay_out(1);
		feed({HC_FILL, 5'd0}, 1'b0);
		feed(8'h55, 1'b0);
		feed(8'h11, 1'b1);
		send_word(CMD_ILLEGAL, 8'hFF, 1'b1);
		pay_out(2);
		feed(HDR_END, 1'b1);
		wait_idle();
	endtask

	// Source end at a boundary and mid-command, and bad copy offsets.
	task automatic test_stream_endings();
		open_stream();
		feed({HC_LITERAL, 5'd2}, 1'b0);
		feed(8'h01, 1'b0);
		feed(8'h02, 1'b0);
		feed(8'h03, 1'b1);
		// The last continue of a run closes the stream.
		open_stream();
		feed({HC_FILL, 5'd2}, 1'b0);
		feed(8'h77, 1'b1);
		pay_out(3);
		open_stream();
		feed({HDR_EXT, HC_FILL, 2'b00}, 1'b1);
		open_stream();
		feed({HDR_EXT, HC_LITERAL, 2'b00}, 1'b0);
		feed(8'h00, 1'b1);
		open_stream();
		feed({HC_LITERAL, 5'd1}, 1'b0);
		feed(8'h10, 1'b1);
		open_stream();
		feed({HC_ALT, 5'd1}, 1'b0);
		feed(8'h01, 1'b1);
		open_stream();
		feed({HC_FILL, 5'd0}, 1'b1);
		// Copy on an empty stream, then copy at exactly the output size.
		open_stream();
		feed({HC_COPY, 5'd0}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h00, 1'b0);
		open_stream();
		feed({HC_LITERAL, 5'd0}, 1'b0);
		feed(8'h42, 1'b0);
		feed({HC_COPY, 5'd0}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h01, 1'b0);
		open_stream();
		feed({HC_LITERAL, 5'd0}, 1'b0);
		feed(8'h42, 1'b0);
		feed({HC_COPY, 5'd0}, 1'b0);
		feed(8'h00, 1'b1);
		open_stream();
		feed({HC_LITERAL, 5'd0}, 1'b0);
		feed(8'h42, 1'b0);
		feed({HC_COPY, 5'd0}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h00, 1'b1);
		pay_out(1);
		wait_idle();
	endtask

	// Copy offset bytes read in both byte orders.
	task automatic test_byte_order();
		write_byte_order(1'b0);
		open_stream();
		feed({HC_LITERAL, 5'd3}, 1'b0);
		feed(8'hC1, 1'b0);
		feed(8'hC2, 1'b0);
		feed(8'hC3, 1'b0);
		feed(8'hC4, 1'b0);
		feed({HC_COPY, 5'd1}, 1'b0);
		feed(8'h02, 1'b0);
		feed(8'h00, 1'b0);
		pay_out(2);
		feed({HC_COPY, 5'd1}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h02, 1'b0);
		write_byte_order(1'b1);
		open_stream();
		feed({HC_LITERAL, 5'd0}, 1'b0);
		feed(8'h3C, 1'b0);
		feed({HC_COPY, 5'd0}, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'h00, 1'b0);
		pay_out(1);
		feed(HDR_END, 1'b0);
		wait_idle();
	endtask

	// Longest extended run.
	task automatic test_long_run();
		open_stream();
		feed({HDR_EXT, HC_FILL, 2'b11}, 1'b0);
		feed(8'hFF, 1'b0);
		feed(8'hE1, 1'b0);
		pay_out(1024);
		feed(HDR_END, 1'b0);
		wait_idle();
	endtask

	// The receiver holds off while words keep coming, so the block must stall its input.
	task automatic test_backpressure();
		src_idle_on = 1'b0;
		-> hold_ev;
		open_stream();
		feed({HC_FILL, 5'd31}, 1'b0);
		feed(8'h3C, 1'b0);
		pay_out(32);
		feed(HDR_END, 1'b0);
		src_idle_on = 1'b1;
		wait_idle();
	endtask

	task automatic test_random_streams(input int target);
		int base;
		base = counted_words;
		while (counted_words - base < target) send_stream();
		wait_idle();
	endtask

	// Compares one taken result word with the oldest expectation.
	task automatic check_result();
		result_t got;
		result_t want;
		got = {dst_if.data_valid, dst_if.out_byte, dst_if.run_pending, dst_if.status};
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("unexpected result word: data_valid %0d out_byte %02h run_pending %0d status %0d",
					got.data_valid, got.out_byte, got.run_pending, got.status);
			end
		end else begin
			want = pending_results.pop_front();
			if (got.data_valid !== want.data_valid || got.out_byte !== want.out_byte ||
					got.run_pending !== want.run_pending || got.status !== want.status) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch: data_valid exp %0d got %0d, out_byte exp %02h got %02h",
						want.data_valid, got.data_valid, want.out_byte, got.out_byte);
					$display("          run_pending exp %0d got %0d, status exp %0d got %0d",
						want.run_pending, got.run_pending, want.status, got.status);
				end
			end
		end
	endtask

	// Result side: takes words with random stalls and checks each one.
	initial begin : result_side
		int stall;
		stall = 0;
		dst_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dst_if.valid && dst_if.ready) begin
				check_result();
			end
			if (hold_on) begin
				dst_if.ready <= 1'b0;
			end else if (stall > 0) begin
				dst_if.ready <= 1'b0;
				stall--;
			end else begin
				dst_if.ready <= 1'b1;
				if (dst_idle_on && $urandom_range(0, 99) < 20) begin
					stall = pick_gap();
				end
			end
		end
	end

	// Long receiver hold-off, counted here.
	initial begin : hold_off
		hold_on = 1'b0;
		forever begin
			@(hold_ev);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		src_if.valid = 1'b0;
		src_if.command = CMD_START;
		src_if.source_byte = '0;
		src_if.last_source_byte = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.offsets_big_endian = 1'b1;
		clear_stream();
		closed = 1'b1;
		cfg_big_endian = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_misuse();
		test_stream_endings();
		test_byte_order();
		test_long_run();
		test_backpressure();
		test_random_streams(70);
		write_byte_order(1'b0);
		test_random_streams(70);
		write_byte_order(1'b1);
		test_random_streams(70);

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
